// ===== rtl/core/scfr_pkg.sv =====
package scfr_pkg;

    localparam int FRAME_LEN_DEF = 64;
    localparam int DATA_W        = 8;
    localparam int IDX_W         = 6;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [DATA_W-1:0] SYNC_RESET = 8'hFF;

    // word index taken from paddr[2]
    localparam logic REG_SYNC_VALUE = 1'b0;

    localparam logic KIND_GOOD = 1'b0;
    localparam logic KIND_FAIL = 1'b1;

    typedef struct packed {
        logic shift;
        logic rotate;
    } chain_ctrl_t;

endpackage

// ===== rtl/core/scfr_if.sv =====
interface scfr_in_if;
    import scfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_out_if;
    import scfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [DATA_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, output kind, output frame_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input frame_byte, input byte_index,
                    input last, output ready);
endinterface

// ===== rtl/core/sync_checksum_frame_receiver.sv =====
// Sync-byte framed receiver with additive checksum.
// in_ch carries received bytes; out_ch carries result requests (kind,
// frame_byte, byte_index, last). The APB port holds sync_value at address 0.
// While empty, bytes other than sync_value are dropped; a sync byte opens a
// frame, held in a row of FRAME_LEN byte cells fed from the tail.
// A byte that does not complete a frame is stored and in_ch stays ready.
// Completing byte: the row rotates once round to sum bytes
// 2 onward, catch the checksum at position 1 and locate the next sync byte.
// Good frame: a second rotation emits FRAME_LEN requests, one per cycle while
// out_ch is ready, last set on the final byte. Bad frame: one failure request,
// and the frame is kept from the next sync byte on (no data moves; only the
// fill count changes), or dropped if none.
// in_ch.ready is low from the completing byte until the frame's requests are
// issued; a stalled out_ch holds the current request in the output register
// and freezes the emit rotation.
// Reset clears the fill count and control, and sets sync_value to 0xFF.
module sync_checksum_frame_receiver #(
    parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [scfr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [scfr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    scfr_in_if.sink                         in_ch,
    scfr_out_if.source                      out_ch
);
    import scfr_pkg::*;

    localparam int CW = $clog2(FRAME_LEN + 1);
    localparam int PW = $clog2(FRAME_LEN);

    typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_EMIT, ST_FAIL} state_t;

    state_t            state_reg;
    logic [CW-1:0]     fill_reg;
    logic [PW-1:0]     cnt_reg;
    logic [PW-1:0]     pos_reg;
    logic              found_reg;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] chk_reg;
    logic [DATA_W-1:0] sync_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [DATA_W-1:0] byte_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              last_reg;

    chain_ctrl_t       ctrl;
    logic [DATA_W-1:0] head;
    logic              in_acc;
    logic              store;
    logic              slot_free;
    logic              cnt_end;
    logic              cfg_wr;
    logic [DATA_W-1:0] sum_next;

    scfr_chain #(.FRAME_LEN(FRAME_LEN)) u_chain (
        .clk (clk),
        .ctrl(ctrl),
        .din (in_ch.rx_byte),
        .head(head)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign store       = in_acc && ((fill_reg != '0) || (in_ch.rx_byte == sync_reg));
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign cnt_end     = (cnt_reg == PW'(FRAME_LEN - 1));
    assign sum_next    = sum_reg + head;

    assign ctrl.shift  = store || (state_reg == ST_SUM) || ((state_reg == ST_EMIT) && slot_free);
    assign ctrl.rotate = (state_reg != ST_IDLE);

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SYNC_VALUE) ? APB_DATA_W'(sync_reg) : '0;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = kind_reg;
    assign out_ch.frame_byte = byte_reg;
    assign out_ch.byte_index = index_reg;
    assign out_ch.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            sum_reg       <= '0;
            chk_reg       <= '0;
            sync_reg      <= SYNC_RESET;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_GOOD;
            byte_reg      <= '0;
            index_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr && (paddr[2] == REG_SYNC_VALUE))
            begin
                sync_reg <= pwdata[DATA_W-1:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (store)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg + 1'b1 == CW'(FRAME_LEN))
                        begin
                            state_reg <= ST_SUM;
                            cnt_reg   <= '0;
                            sum_reg   <= '0;
                            found_reg <= 1'b0;
                        end
                    end
                end
                ST_SUM:
                begin
                    if (cnt_reg == PW'(1))
                    begin
                        chk_reg <= head;
                    end
                    if (cnt_reg >= PW'(2))
                    begin
                        sum_reg <= sum_next;
                    end
                    if ((cnt_reg != '0) && !found_reg && (head == sync_reg))
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= cnt_reg;
                    end
                    if (cnt_end)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (sum_next == chk_reg) ? ST_EMIT : ST_FAIL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_GOOD;
                        byte_reg      <= head;
                        index_reg     <= IDX_W'(cnt_reg);
                        last_reg      <= cnt_end;
                        if (cnt_end)
                        begin
                            state_reg <= ST_IDLE;
                            fill_reg  <= '0;
                            cnt_reg   <= '0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_FAIL:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_FAIL;
                        byte_reg      <= '0;
                        index_reg     <= '0;
                        last_reg      <= 1'b1;
                        fill_reg      <= found_reg ? (CW'(FRAME_LEN) - CW'(pos_reg)) : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/scfr_cell.sv =====
module scfr_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic [scfr_pkg::DATA_W-1:0] d,
    output logic [scfr_pkg::DATA_W-1:0] q
);
    import scfr_pkg::*;

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ===== rtl/core/scfr_chain.sv =====
module scfr_chain #(
    parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEF
) (
    input  logic                        clk,
    input  scfr_pkg::chain_ctrl_t       ctrl,
    input  logic [scfr_pkg::DATA_W-1:0] din,
    output logic [scfr_pkg::DATA_W-1:0] head
);
    import scfr_pkg::*;

    logic [DATA_W-1:0] q [FRAME_LEN];
    logic [DATA_W-1:0] tail_d;

    // new bytes enter at the tail; a rotation feeds the head back round
    assign tail_d = ctrl.rotate ? q[0] : din;

    genvar i;
    generate
        for (i = 0; i < FRAME_LEN; i++)
        begin : g_cell
            if (i == FRAME_LEN - 1)
            begin : g_tail
                scfr_cell u_cell (.clk(clk), .en(ctrl.shift), .d(tail_d), .q(q[i]));
            end
            else
            begin : g_body
                scfr_cell u_cell (.clk(clk), .en(ctrl.shift), .d(q[i+1]), .q(q[i]));
            end
        end
    endgenerate

    assign head = q[0];

endmodule

// ===== rtl/core/scfr_checker.sv =====
module scfr_checker #(
    parameter int FRAME_LEN = scfr_pkg::FRAME_LEN_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        kind,
    input logic [scfr_pkg::DATA_W-1:0] frame_byte,
    input logic [scfr_pkg::IDX_W-1:0]  byte_index,
    input logic                        last
);
    import scfr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frame_byte)
            && $stable(byte_index) && $stable(last))
        else $error("result request changed while stalled");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_FAIL) |-> last && (frame_byte == '0) && (byte_index == '0))
        else $error("malformed checksum failure request");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_GOOD) && last |-> byte_index == IDX_W'(FRAME_LEN - 1))
        else $error("frame ended at wrong byte index");

    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_GOOD) && !last |-> !in_ready)
        else $error("input taken in the middle of a frame emit");

endmodule

bind sync_checksum_frame_receiver scfr_checker #(.FRAME_LEN(FRAME_LEN)) u_scfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .frame_byte(out_ch.frame_byte),
    .byte_index(out_ch.byte_index),
    .last      (out_ch.last)
);
